// ===== hw/rtl/integer_square_root_macros.svh =====
// ----------------------------------------------------------------------------
// integer_square_root_macros
// assertion macros shared by the square root rtl, sampled on clk, held off
// while rst_n is low
// ----------------------------------------------------------------------------
`ifndef INTEGER_SQUARE_ROOT_MACROS_SVH
`define INTEGER_SQUARE_ROOT_MACROS_SVH

// consequent checked in the same cycle
`define ISQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ISQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/isqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// isqrt_pkg
// widths and defaults for the pipelined integer square root
// ----------------------------------------------------------------------------
package isqrt_pkg;

  localparam int RADICAND_BITS_DEF = 31;
  localparam int ROOT_OUT_BITS     = 16;

endpackage

// ===== hw/rtl/integer_square_root.sv =====
// ----------------------------------------------------------------------------
// integer_square_root
// floor of the square root of an unsigned radicand, one root bit per stage
//
//   channel  dir  tdata                         tuser  tlast
//   in_      in   radicand [RADICAND_BITS-1:0]  -      -
//   out_     out  root [15:0]                   -      -
//
// one beat per cycle while out_tready is high; each beat passes through the
// chain of restoring subtract stages, one root bit each, registered per stage
// each stage holds its beat until the next stage can take it, so bubbles
// collapse and a stall loses or repeats nothing
// rst_n clears the stage valid bits only
// ----------------------------------------------------------------------------
module integer_square_root
  import isqrt_pkg::*;
#(
  parameter int RADICAND_BITS = RADICAND_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((RADICAND_BITS+7)/8)*8-1:0]   in_tdata,   // radicand
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ROOT_OUT_BITS-1:0]             out_tdata   // root
);

`include "integer_square_root_macros.svh"

  localparam int ROOT_BITS = (RADICAND_BITS + 1) / 2;
  localparam int PAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 1;
  localparam int CUR_BITS  = ROOT_BITS + 3;
  localparam int LAST      = ROOT_BITS - 1;

  logic [PAD_BITS-1:0]  rad_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];
  logic [REM_BITS-1:0]  rem_r  [ROOT_BITS];
  logic                 vld_r  [ROOT_BITS];
  logic                 rdy    [ROOT_BITS+1];

  assign rdy[ROOT_BITS] = out_tready;

  for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
    localparam int POS = ROOT_BITS - 1 - s;

    logic [PAD_BITS-1:0]  rad_prev;
    logic [ROOT_BITS-1:0] root_prev;
    logic [REM_BITS-1:0]  rem_prev;
    logic                 vld_prev;
    logic [CUR_BITS-1:0]  cur;
    logic [CUR_BITS-1:0]  trial;
    logic [CUR_BITS-1:0]  diff;
    logic                 keep;
    logic [ROOT_BITS-1:0] root_nxt;
    logic [REM_BITS-1:0]  rem_nxt;

    if (s == 0) begin : g_head
      assign rad_prev  = PAD_BITS'(in_tdata[RADICAND_BITS-1:0]);
      assign root_prev = '0;
      assign rem_prev  = '0;
      assign vld_prev  = in_tvalid;
    end else begin : g_body
      assign rad_prev  = rad_r[s-1];
      assign root_prev = root_r[s-1];
      assign rem_prev  = rem_r[s-1];
      assign vld_prev  = vld_r[s-1];
    end

    // bring down the next radicand bit pair, try root*4+1
    assign cur      = {rem_prev, rad_prev[2*POS+1 -: 2]};
    assign trial    = CUR_BITS'({root_prev, 2'b01});
    assign diff     = cur - trial;
    assign keep     = cur >= trial;
    assign rem_nxt  = keep ? diff[REM_BITS-1:0] : cur[REM_BITS-1:0];
    assign root_nxt = (root_prev << 1) | ROOT_BITS'(keep);

    assign rdy[s] = !vld_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_r[s] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vld_prev) begin
        rad_r[s]  <= rad_prev;
        root_r[s] <= root_nxt;
        rem_r[s]  <= rem_nxt;
      end
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = ROOT_OUT_BITS'(root_r[LAST]);

  `ISQ_ASSERT_NOW(a_rem_bound, vld_r[LAST], REM_BITS'(rem_r[LAST]) <= {root_r[LAST], 1'b0}, "remainder exceeds twice the root")
  `ISQ_ASSERT_NOW(a_zero_root, vld_r[LAST] && (rad_r[LAST] == '0), root_r[LAST] == '0, "zero radicand gave nonzero root")
  `ISQ_ASSERT_NEXT(a_beat_lands, in_tvalid && in_tready, vld_r[0], "accepted beat missing from first stage")

endmodule

// ===== dv/tb_integer_square_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_square_root
// drives radicands into the square root pipeline and checks every root beat
// in order against a bit-by-bit floor square root computed in the bench,
// under phases of sender idling, receiver stalling and a long output hold-off
// ----------------------------------------------------------------------------
module tb_integer_square_root;
  import isqrt_pkg::*;

  localparam int RAD_W      = RADICAND_BITS_DEF;
  localparam int IN_W       = ((RAD_W + 7) / 8) * 8;
  localparam int ROOT_W     = (RAD_W + 1) / 2;
  localparam int LATENCY    = (RAD_W + 1) / 2;
  localparam int HOLD_LEN   = 300;
  localparam int CYCLE_CAP  = 250000;
  localparam int SHOW_ERRS  = 10;

  class root_scoreboard;
    logic [ROOT_OUT_BITS-1:0] pending_roots[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic [ROOT_OUT_BITS-1:0] floor_root(logic [IN_W-1:0] word);
      longint unsigned value;
      longint unsigned acc;
      longint unsigned trial;
      value = longint'(word) & ((64'd1 << RAD_W) - 1);
      acc = 0;
      for (int pos = ROOT_W - 1; pos >= 0; pos--) begin
        trial = acc | (64'd1 << pos);
        if (trial * trial <= value) acc = trial;
      end
      return acc[ROOT_OUT_BITS-1:0];
    endfunction

    function void note_radicand(logic [IN_W-1:0] word);
      pending_roots.push_back(floor_root(word));
    endfunction

    function void check_root(logic [ROOT_OUT_BITS-1:0] got);
      logic [ROOT_OUT_BITS-1:0] want;
      if (pending_roots.size() == 0) begin
        errors++;
        if (errors <= SHOW_ERRS) $display("root beat %0d with nothing pending", got);
      end else begin
        want = pending_roots.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= SHOW_ERRS) $display("root mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [ROOT_OUT_BITS-1:0] out_tdata;

  root_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  cycles = 0;

  integer_square_root #(.RADICAND_BITS(RAD_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // monitors for both channels
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_radicand(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_root(out_tdata);
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic [IN_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // step past the current edge before polling, so the last accepted beat is already noted
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_roots.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] pick_radicand();
    logic [IN_W-1:0] word;
    int unsigned r;
    case ($urandom_range(3))
      0: word = $urandom;
      1: begin
        // around perfect squares, where the last root bit flips
        r = $urandom_range(46340);
        word = r * r + $urandom_range(2) - 1;
      end
      2: word = $urandom_range(300);
      default: word = (32'd1 << $urandom_range(RAD_W - 1)) - $urandom_range(1);
    endcase
    word[IN_W-1] = 1'($urandom_range(1));
    return word;
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_beat(pick_radicand());
    wait_drained();
  endtask

  logic [IN_W-1:0] directed[] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004,
    32'h0000_0008, 32'h0000_000F, 32'h0000_0010, 32'h0000_0018, 32'h0000_0019,
    32'h3FFF_FFFF, 32'h4000_0000, 32'd2147395599, 32'd2147395600, 32'h7FFF_FFFE,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0019, 32'hFFFF_FFFF, 32'h5555_5555,
    32'hAAAA_AAAA
  };

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_beat(directed[i]);
    wait_drained();

    // back pressure: output held off while the sender keeps offering beats
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (40) send_beat(pick_radicand());
    wait_drained();

    run_phase(0, 0, 100);
    run_phase(77, 0, 100);
    run_phase(0, 77, 100);
    run_phase(34, 34, 100);

    repeat (LATENCY + 24) @(posedge clk);
    sb.errors += sb.pending_roots.size();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/isqrt_pkg.sv
hw/rtl/integer_square_root.sv
dv/tb_integer_square_root.sv
